// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/lrupr_pkg.sv =====
// Types, constants and helpers for the LRU page replacement block.
`timescale 1ns / 1ps

package lrupr_pkg;

    localparam int FRAMES  = 8;
    localparam int PAGE_W  = 8;
    localparam int FRAME_W = 3;
    localparam int RANK_W  = 3;
    localparam int CNT_W   = 4;
    localparam int CFG_W   = 4;
    localparam int FAULT_W = 16;

    typedef logic [PAGE_W-1:0]   page_t;
    typedef logic [FRAME_W-1:0]  frame_idx_t;
    typedef logic [RANK_W-1:0]   rank_t;
    typedef logic [CNT_W-1:0]    count_t;
    typedef logic [CFG_W-1:0]    cfg_t;
    typedef logic [FAULT_W-1:0]  fault_cnt_t;

    typedef page_t [FRAMES-1:0] page_array_t;
    typedef rank_t [FRAMES-1:0] rank_array_t;

    typedef struct packed {
        logic       hit;
        frame_idx_t idx;
    } match_t;

    // Zero acts as one frame, anything above FRAMES acts as FRAMES.
    function automatic count_t clamp_frames(input cfg_t value);
        count_t result;
        if (value == '0)
        begin
            result = count_t'(1);
        end
        else if (value > cfg_t'(FRAMES))
        begin
            result = count_t'(FRAMES);
        end
        else
        begin
            result = count_t'(value);
        end
        return result;
    endfunction

endpackage

// ===== rtl/lrupr_match.sv =====
// Associative page lookup over the searched frames, first match wins.
`timescale 1ns / 1ps

module lrupr_match
(
    input  lrupr_pkg::page_t       page,
    input  lrupr_pkg::page_array_t frame_page,
    input  lrupr_pkg::count_t      search_count,
    output lrupr_pkg::match_t      match
);
    import lrupr_pkg::*;

    always_comb
    begin
        match = '0;
        // Descending scan so the lowest matching frame is kept.
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if ((count_t'(i) < search_count) && (frame_page[i] == page))
            begin
                match.hit = 1'b1;
                match.idx = frame_idx_t'(i);
            end
        end
    end

endmodule

// ===== rtl/lrupr_recency.sv =====
// Recency ranks: victim selection and promotion of the referenced frame.
`timescale 1ns / 1ps

module lrupr_recency
(
    input  lrupr_pkg::rank_array_t rank,
    input  lrupr_pkg::count_t      active,
    input  lrupr_pkg::count_t      filled_next,
    input  lrupr_pkg::frame_idx_t  idx,
    input  lrupr_pkg::count_t      old_rank,
    output lrupr_pkg::frame_idx_t  victim,
    output lrupr_pkg::rank_array_t rank_next
);
    import lrupr_pkg::*;

    // Oldest frame among those in use; ties keep the lower frame.
    always_comb
    begin
        victim = '0;
        for (int i = 1; i < FRAMES; i++)
        begin
            if ((count_t'(i) < active) && (rank[i] > rank[victim]))
            begin
                victim = frame_idx_t'(i);
            end
        end
    end

    // Filled frames younger than the old rank age by one; idx becomes newest.
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            if (frame_idx_t'(i) == idx)
            begin
                rank_next[i] = '0;
            end
            else if ((count_t'(i) < filled_next) && (count_t'(rank[i]) < old_rank))
            begin
                rank_next[i] = rank[i] + rank_t'(1);
            end
            else
            begin
                rank_next[i] = rank[i];
            end
        end
    end

endmodule

// ===== rtl/lru_page_replacement.sv =====
// Top level of the LRU page replacement block.
`timescale 1ns / 1ps

// One page reference per cycle: a request taken with start is registered,
// looked up against the resident frames within the configured frame count
// and ranked in the next cycle; its result appears with done in the cycle after
// that. busy is always low; done pulses for one cycle and cannot be held off,
// so the receiver must take every result as it comes. The frame count is
// written through the cfg channel, only while no request is in flight;
// cfg_ready is low in the cycle a request is being processed.

`include "assert_macros.svh"

module lru_page_replacement
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  lrupr_pkg::page_t        page,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  lrupr_pkg::cfg_t         cfg_data,
    output logic                    done,
    output logic                    fault,
    output lrupr_pkg::frame_idx_t   frame_index,
    output logic                    evicted_valid,
    output lrupr_pkg::page_t        evicted_page,
    output lrupr_pkg::fault_cnt_t   fault_count
);
    import lrupr_pkg::*;

    logic        req_valid_reg;
    page_t       page_reg;
    count_t      active_reg;
    count_t      filled_reg;
    count_t      filled_next;
    rank_array_t rank_reg;
    rank_array_t rank_next;
    page_array_t frame_page_reg;
    fault_cnt_t  fault_total_reg;
    fault_cnt_t  fault_total_next;

    logic        done_reg;
    logic        fault_reg;
    frame_idx_t  frame_index_reg;
    logic        evicted_valid_reg;
    page_t       evicted_page_reg;

    count_t      search_count;
    match_t      match;
    frame_idx_t  victim;
    logic        miss;
    logic        fill;
    frame_idx_t  idx;
    count_t      old_rank;

    assign busy      = 1'b0;
    assign cfg_ready = !req_valid_reg;

    assign search_count = (filled_reg < active_reg) ? filled_reg : active_reg;

    lrupr_match u_match
    (
        .page         (page_reg),
        .frame_page   (frame_page_reg),
        .search_count (search_count),
        .match        (match)
    );

    lrupr_recency u_recency
    (
        .rank        (rank_reg),
        .active      (active_reg),
        .filled_next (filled_next),
        .idx         (idx),
        .old_rank    (old_rank),
        .victim      (victim),
        .rank_next   (rank_next)
    );

    always_comb
    begin
        miss = !match.hit;
        fill = miss && (filled_reg < active_reg);
        if (match.hit)
        begin
            idx = match.idx;
        end
        else if (fill)
        begin
            idx = frame_idx_t'(filled_reg);
        end
        else
        begin
            idx = victim;
        end
        filled_next = fill ? (filled_reg + count_t'(1)) : filled_reg;
        // A fill ages every filled frame.
        old_rank = fill ? count_t'(FRAMES) : count_t'(rank_reg[idx]);
        if (miss && (fault_total_reg != '1))
        begin
            fault_total_next = fault_total_reg + fault_cnt_t'(1);
        end
        else
        begin
            fault_total_next = fault_total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg   <= 1'b0;
            active_reg      <= count_t'(FRAMES);
            filled_reg      <= '0;
            rank_reg        <= '0;
            fault_total_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= clamp_frames(cfg_data);
            end
            if (req_valid_reg)
            begin
                filled_reg      <= filled_next;
                rank_reg        <= rank_next;
                fault_total_reg <= fault_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            page_reg <= page;
        end
        if (req_valid_reg)
        begin
            if (miss)
            begin
                frame_page_reg[idx] <= page_reg;
            end
            fault_reg         <= miss;
            frame_index_reg   <= idx;
            evicted_valid_reg <= miss && !fill;
            evicted_page_reg  <= (miss && !fill) ? frame_page_reg[idx] : '0;
        end
    end

    assign done          = done_reg;
    assign fault         = fault_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_count   = fault_total_reg;

    `ASSERT_IMPLIES(a_evict_is_fault, clk, rst_n, done && evicted_valid, fault)
    `ASSERT_IMPLIES(a_filled_bound, clk, rst_n, 1'b1, filled_reg <= count_t'(FRAMES))
    `ASSERT_NEXT(a_fill_advances, clk, rst_n, req_valid_reg && fill,
        filled_reg == ($past(filled_reg) + count_t'(1)))
    `ASSERT_NEXT(a_count_monotonic, clk, rst_n, 1'b1, fault_total_reg >= $past(fault_total_reg))

endmodule

// ===== dv/tb_lru_page_replacement.sv =====
// Self-checking testbench for the LRU page replacement block.
`timescale 1ns / 1ps

module tb_lru_page_replacement;
    import lrupr_pkg::*;

    localparam int STALL_LIMIT = 1000;

    typedef struct {
        logic       fault;
        frame_idx_t frame;
        logic       ev_valid;
        page_t      ev_page;
        fault_cnt_t count;
    } lookup_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    page_t      page = '0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_t       cfg_data = '0;
    logic       done;
    logic       fault;
    frame_idx_t frame_index;
    logic       evicted_valid;
    page_t      evicted_page;
    fault_cnt_t fault_count;

    // predictor state
    page_t  resident_page [FRAMES];
    int     frame_rank [FRAMES];
    int     frames_loaded = 0;
    int     fault_tally = 0;
    cfg_t   frames_cfg = cfg_t'(8);

    page_t          page_refs [$];
    lookup_result_t pending_lookups [$];
    lookup_result_t want;
    int             idle_pct = 27;
    int             errors = 0;
    int             quiet_cycles = 0;

    lru_page_replacement uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page          (page),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .fault         (fault),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Move frame idx to rank 0; filled frames newer than old_rank age by one.
    function automatic void touch_frame(input int idx, input int old_rank);
        for (int i = 0; i < frames_loaded && i < FRAMES; i++)
        begin
            if (i != idx && frame_rank[i] < old_rank)
            begin
                frame_rank[i]++;
            end
        end
        frame_rank[idx] = 0;
    endfunction

    function automatic lookup_result_t predict_lookup(input page_t pg);
        lookup_result_t r;
        int  usable;
        int  span;
        int  idx;
        bit  found;
        r.fault    = 1'b1;
        r.ev_valid = 1'b0;
        r.ev_page  = '0;
        usable = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
        span   = (frames_loaded < usable) ? frames_loaded : usable;
        found  = 1'b0;
        idx    = 0;
        for (int i = 0; i < span; i++)
        begin
            if (!found && resident_page[i] == pg)
            begin
                found = 1'b1;
                idx   = i;
            end
        end
        if (found)
        begin
            r.fault = 1'b0;
            touch_frame(idx, frame_rank[idx]);
        end
        else
        begin
            if (fault_tally < 65535)
            begin
                fault_tally++;
            end
            if (frames_loaded < usable)
            begin
                idx = frames_loaded;
                frames_loaded++;
                resident_page[idx] = pg;
                touch_frame(idx, FRAMES);
            end
            else
            begin
                idx = 0;
                for (int i = 1; i < usable; i++)
                begin
                    if (frame_rank[i] > frame_rank[idx])
                    begin
                        idx = i;
                    end
                end
                r.ev_valid = 1'b1;
                r.ev_page  = resident_page[idx];
                resident_page[idx] = pg;
                touch_frame(idx, frame_rank[idx]);
            end
        end
        r.frame = frame_idx_t'(idx);
        r.count = fault_cnt_t'(fault_tally);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
            errors++;
        end
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                pending_lookups.push_back(predict_lookup(page));
            end
            if (!(start && busy))
            begin
                if (page_refs.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    start <= 1'b1;
                    page  <= page_refs.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_lookups.size() == 0)
            begin
                $error("result with no request pending: frame_index %0d", frame_index);
                errors++;
            end
            else
            begin
                want = pending_lookups.pop_front();
                check_field("fault", 16'(want.fault), 16'(fault));
                check_field("frame_index", 16'(want.frame), 16'(frame_index));
                check_field("evicted_valid", 16'(want.ev_valid), 16'(evicted_valid));
                check_field("evicted_page", 16'(want.ev_page), 16'(evicted_page));
                check_field("fault_count", want.count, fault_count);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done === 1'b1 || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sample at the falling edge so the driver's updates have settled.
    task automatic drain();
        while (page_refs.size() > 0 || start || pending_lookups.size() > 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_frames(input cfg_t value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (cfg_ready !== 1'b1);
        frames_cfg = value;
        cfg_valid <= 1'b0;
        cfg_data  <= cfg_t'($urandom_range(15));
    endtask

    // Mostly a small working set so hits and evictions are frequent.
    task automatic queue_random_refs(input int count);
        page_t pool [12];
        int    ws;
        for (int i = 0; i < 12; i++)
        begin
            pool[i] = page_t'($urandom_range(255));
        end
        ws = $urandom_range(1, 12);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 85)
            begin
                page_refs.push_back(pool[$urandom_range(ws - 1)]);
            end
            else
            begin
                page_refs.push_back(page_t'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        cfg_t  sweep [9];
        page_t warmup [13];
        warmup = '{8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h01,
                   8'h80, 8'h33, 8'h00, 8'h99, 8'h55};
        sweep = '{4'd1, 4'd8, 4'd4, 4'd15, 4'd0, 4'd2, 4'd6, 4'd9, 4'd3};
        sweep[8] = cfg_t'($urandom_range(15));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill all eight frames, hits, then LRU evictions
        foreach (warmup[i])
        begin
            page_refs.push_back(warmup[i]);
        end
        // shrink after fill: upper frames hidden, then visible again
        write_frames(cfg_t'(3));
        page_refs.push_back(8'h80);
        page_refs.push_back(8'h00);
        page_refs.push_back(8'h01);
        write_frames(cfg_t'(8));
        page_refs.push_back(8'h01);
        page_refs.push_back(8'hF0);
        // zero acts as one frame, above range acts as all frames
        write_frames(cfg_t'(0));
        page_refs.push_back(8'h12);
        page_refs.push_back(8'h34);
        write_frames(cfg_t'(15));
        page_refs.push_back(8'h80);
        page_refs.push_back(8'hFF);

        foreach (sweep[i])
        begin
            write_frames(sweep[i]);
            idle_pct = (i == 4) ? 0 : 27;
            queue_random_refs(60);
        end

        write_frames(cfg_t'(8));
        idle_pct = 27;
        queue_random_refs(40);

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lrupr_pkg.sv
rtl/lrupr_match.sv
rtl/lrupr_recency.sv
rtl/lru_page_replacement.sv
dv/tb_lru_page_replacement.sv
